[rtl/core/pptrk_pkg.sv]
// ----------------------------------------------------------------------------
// pptrk_pkg
// Shared types and constants of the pointer packet cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pptrk_pkg;

   // Cursor coordinate width used when the top level is not told otherwise.
   localparam int COORD_WIDTH_DEFAULT = 12;

   // Screen size registers.
   localparam int SIZE_WIDTH = 13;
   localparam logic [SIZE_WIDTH-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_WIDTH-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   // Register port.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   // Header byte bit positions.
   localparam int HDR_LEFT_BIT   = 0;
   localparam int HDR_RIGHT_BIT  = 1;
   localparam int HDR_MIDDLE_BIT = 2;
   localparam int HDR_SYNC_BIT   = 3;
   localparam int HDR_XSIGN_BIT  = 4;
   localparam int HDR_YSIGN_BIT  = 5;

   typedef struct packed {
      logic [SIZE_WIDTH-1:0] screen_width;
      logic [SIZE_WIDTH-1:0] screen_height;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/core/pointer_packet_cursor_tracker_core.sv]
// ----------------------------------------------------------------------------
// pointer_packet_cursor_tracker_core
// Frames three-byte pointing-device packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// The block takes one byte beat per clock while req_stall is low. Each
// accepted byte is held in an input register, then the framer and the
// cursor update act on it, and the result of a packet is written from
// there into the output register that drives the rsp channel. A result
// held by rsp_stall stays in the output register; one more byte is accepted
// into the input register while it waits, and req_stall rises only while
// both registers are occupied and the output is stalled. Bytes with
// req_aux_data low are dropped, as are headers without their sync bit. The
// screen size registers are at byte addresses 0 (width) and 4 (height) and
// should be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_packet_cursor_tracker_core #(
   parameter int COORD_WIDTH = pptrk_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [7:0]                           req_data_byte,
   input  wire                                  req_aux_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [COORD_WIDTH-1:0]               rsp_cursor_x,
   output logic [COORD_WIDTH-1:0]               rsp_cursor_y,
   output logic [2:0]                           rsp_buttons,
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [pptrk_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire  [pptrk_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [pptrk_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                 pready
);
   import pptrk_pkg::*;

   cfg_type                cfg;
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff,  in_byte_in;
   logic                   in_aux_ff,   in_aux_in;
   logic                   out_free;
   logic                   step;
   logic                   result_valid;
   logic [COORD_WIDTH-1:0] cursor_x;
   logic [COORD_WIDTH-1:0] cursor_y;
   logic [2:0]             buttons;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_WIDTH-1:0] rsp_x_ff,     rsp_x_in;
   logic [COORD_WIDTH-1:0] rsp_y_ff,     rsp_y_in;
   logic [2:0]             rsp_btn_ff,   rsp_btn_in;

   pptrk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The held byte moves on whenever the output register is empty or is
   // being emptied in this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_aux_in   = in_aux_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_data_byte;
         in_aux_in   = req_aux_data;
      end
   end

   pptrk_decoder #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .aux_data     (in_aux_ff),
      .cfg          (cfg),
      .result_valid (result_valid),
      .cursor_x     (cursor_x),
      .cursor_y     (cursor_y),
      .buttons      (buttons)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_btn_in   = rsp_btn_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = cursor_x;
         rsp_y_in     = cursor_y;
         rsp_btn_in   = buttons;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_aux_ff  <= in_aux_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_btn_ff <= rsp_btn_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cursor_x = rsp_x_ff;
   assign rsp_cursor_y = rsp_y_ff;
   assign rsp_buttons  = rsp_btn_ff;

endmodule

`default_nettype wire

[rtl/core/pptrk_csr.sv]
// ----------------------------------------------------------------------------
// pptrk_csr
// Screen size registers behind the APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

module pptrk_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [pptrk_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire  [pptrk_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [pptrk_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                 pready,
   output pptrk_pkg::cfg_type                   cfg
);
   import pptrk_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_sel;

   // Registers sit on 4-byte boundaries; the low address bits are not decoded.
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = pwdata[SIZE_WIDTH-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = pwdata[SIZE_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_sel)
         REG_SCREEN_WIDTH:  prdata[SIZE_WIDTH-1:0] = cfg_ff.screen_width;
         REG_SCREEN_HEIGHT: prdata[SIZE_WIDTH-1:0] = cfg_ff.screen_height;
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/pptrk_decoder.sv]
// ----------------------------------------------------------------------------
// pptrk_decoder
// Packet framer, button decode and clamped cursor update for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pptrk_decoder #(
   parameter int COORD_WIDTH = pptrk_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step,
   input  wire  [7:0]               data_byte,
   input  wire                      aux_data,
   input  pptrk_pkg::cfg_type       cfg,
   output logic                     result_valid,
   output logic [COORD_WIDTH-1:0]   cursor_x,
   output logic [COORD_WIDTH-1:0]   cursor_y,
   output logic [2:0]               buttons
);
   import pptrk_pkg::*;

   // Signed working width that holds the position plus a 9-bit move and
   // any screen size limit.
   localparam int SW = (COORD_WIDTH + 2 > SIZE_WIDTH + 1) ? COORD_WIDTH + 2 : SIZE_WIDTH + 1;
   localparam logic signed [SW-1:0] COORD_MAX = SW'((2 ** COORD_WIDTH) - 1);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_XMOVE,
      PH_YMOVE
   } phase_type;

   phase_type              phase_ff,  phase_in;
   logic [7:0]             header_ff, header_in;
   logic [7:0]             xmove_ff,  xmove_in;
   logic [COORD_WIDTH-1:0] pos_x_ff,  pos_x_in;
   logic [COORD_WIDTH-1:0] pos_y_ff,  pos_y_in;
   logic [2:0]             buttons_ff, buttons_in;

   logic                   take;
   logic                   last_byte;
   logic [8:0]             dx;
   logic [8:0]             dy;
   logic signed [SW-1:0]   sum_x;
   logic signed [SW-1:0]   sum_y;
   logic signed [SW-1:0]   top_x;
   logic signed [SW-1:0]   top_y;
   logic [2:0]             new_buttons;
   logic [COORD_WIDTH-1:0] new_x;
   logic [COORD_WIDTH-1:0] new_y;

   function automatic logic signed [SW-1:0] limit_of(input logic [SIZE_WIDTH-1:0] size);
      logic [SIZE_WIDTH-1:0] size_m1;
      logic signed [SW-1:0]  lim;
      begin
         // A zero size behaves as a one-pixel screen.
         size_m1 = (size == '0) ? '0 : size - 1'b1;
         lim     = signed'({{(SW - SIZE_WIDTH){1'b0}}, size_m1});
         return (lim > COORD_MAX) ? COORD_MAX : lim;
      end
   endfunction

   function automatic logic [COORD_WIDTH-1:0] clamp(input logic signed [SW-1:0] v,
                                                    input logic signed [SW-1:0] top);
      begin
         if (v < 0) begin
            return '0;
         end else if (v > top) begin
            return top[COORD_WIDTH-1:0];
         end else begin
            return v[COORD_WIDTH-1:0];
         end
      end
   endfunction

   assign take      = step && aux_data;
   assign last_byte = (phase_ff == PH_YMOVE);

   assign dx = {header_ff[HDR_XSIGN_BIT], xmove_ff};
   assign dy = {header_ff[HDR_YSIGN_BIT], data_byte};

   assign sum_x = signed'({{(SW - COORD_WIDTH){1'b0}}, pos_x_ff}) + {{(SW - 9){dx[8]}}, dx};
   assign sum_y = signed'({{(SW - COORD_WIDTH){1'b0}}, pos_y_ff}) - {{(SW - 9){dy[8]}}, dy};
   assign top_x = limit_of(cfg.screen_width);
   assign top_y = limit_of(cfg.screen_height);
   assign new_x = clamp(sum_x, top_x);
   assign new_y = clamp(sum_y, top_y);

   assign new_buttons = {header_ff[HDR_LEFT_BIT], header_ff[HDR_MIDDLE_BIT],
                         header_ff[HDR_RIGHT_BIT]};

   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      xmove_in   = xmove_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      buttons_in = buttons_ff;
      if (take) begin
         case (phase_ff)
            PH_XMOVE: begin
               xmove_in = data_byte;
               phase_in = PH_YMOVE;
            end
            PH_YMOVE: begin
               phase_in   = PH_HEADER;
               pos_x_in   = new_x;
               pos_y_in   = new_y;
               buttons_in = new_buttons;
            end
            default: begin
               // A header without its sync bit is dropped to regain framing.
               header_in = data_byte;
               phase_in  = data_byte[HDR_SYNC_BIT] ? PH_XMOVE : PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         header_ff  <= '0;
         xmove_ff   <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         buttons_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         header_ff  <= header_in;
         xmove_ff   <= xmove_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         buttons_ff <= buttons_in;
      end
   end

   assign result_valid = take && last_byte;
   assign cursor_x     = pos_x_in;
   assign cursor_y     = pos_y_in;
   assign buttons      = buttons_in;

endmodule

`default_nettype wire

[sim/pointer_packet_cursor_tracker_core_checker.sv]
// ----------------------------------------------------------------------------
// pointer_packet_cursor_tracker_core_checker
// Watches the byte, cursor and register ports and checks every cursor beat.
// ----------------------------------------------------------------------------
// Every accepted aux byte goes through a packet framer and cursor tracker of
// its own. A finished packet pushes the expected cursor beat onto a queue.
// Each accepted cursor beat is then compared field by field with the oldest
// entry. Register writes are picked up from the register port as they happen.
// ----------------------------------------------------------------------------
module pointer_packet_cursor_tracker_core_checker #(
   parameter int COORD_WIDTH = pptrk_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_aux_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [COORD_WIDTH-1:0]               rsp_cursor_x,
   input  logic [COORD_WIDTH-1:0]               rsp_cursor_y,
   input  logic [2:0]                           rsp_buttons,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [pptrk_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [pptrk_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output int                                   failures,
   output int                                   pending,
   output int                                   packets_checked,
   output int                                   bytes_taken
);
   timeunit 1ns;
   timeprecision 1ps;
   import pptrk_pkg::*;

   localparam logic [CSR_ADDR_WIDTH-1:0] WIDTH_ADDR  = {REG_SCREEN_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] HEIGHT_ADDR = {REG_SCREEN_HEIGHT, 2'b00};

   typedef enum logic [1:0] {
      FRAME_HEADER,
      FRAME_X,
      FRAME_Y
   } frame_phase_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [2:0]             buttons;
   } cursor_report_type;

   frame_phase_type        frame;
   logic [7:0]             held_header;
   logic [7:0]             held_x;
   logic [COORD_WIDTH-1:0] cur_x;
   logic [COORD_WIDTH-1:0] cur_y;
   logic [SIZE_WIDTH-1:0]  width_reg;
   logic [SIZE_WIDTH-1:0]  height_reg;
   cursor_report_type      cursor_q[$];

   // A zero size behaves as one pixel, and sizes past the coordinate range
   // saturate at the largest coordinate.
   function automatic logic [COORD_WIDTH-1:0] clamp_to_screen(int v,
                                                              logic [SIZE_WIDTH-1:0] size);
      int limit;
      limit = (size == 0) ? 0 : int'(size) - 1;
      if (limit > (1 << COORD_WIDTH) - 1)
         limit = (1 << COORD_WIDTH) - 1;
      if (v < 0)
         return '0;
      if (v > limit)
         return COORD_WIDTH'(limit);
      return COORD_WIDTH'(v);
   endfunction

   function automatic int move9(logic [7:0] low, logic neg);
      return neg ? int'(low) - 256 : int'(low);
   endfunction

   task automatic advance_framer(logic [7:0] b);
      cursor_report_type r;
      int dx;
      int dy;
      case (frame)
         FRAME_X: begin
            held_x = b;
            frame = FRAME_Y;
         end
         FRAME_Y: begin
            frame = FRAME_HEADER;
            dx = move9(held_x, held_header[HDR_XSIGN_BIT]);
            dy = move9(b, held_header[HDR_YSIGN_BIT]);
            // Device Y grows upward while screen rows grow downward.
            cur_x = clamp_to_screen(int'(cur_x) + dx, width_reg);
            cur_y = clamp_to_screen(int'(cur_y) - dy, height_reg);
            r.x = cur_x;
            r.y = cur_y;
            r.buttons = {held_header[HDR_LEFT_BIT], held_header[HDR_MIDDLE_BIT],
                         held_header[HDR_RIGHT_BIT]};
            cursor_q.push_back(r);
         end
         default: begin
            held_header = b;
            frame = b[HDR_SYNC_BIT] ? FRAME_X : FRAME_HEADER;
         end
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      failures++;
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      cursor_report_type want;
      if (reset) begin
         frame = FRAME_HEADER;
         held_header = '0;
         held_x = '0;
         cur_x = '0;
         cur_y = '0;
         width_reg = SCREEN_WIDTH_RESET;
         height_reg = SCREEN_HEIGHT_RESET;
         cursor_q.delete();
         failures = 0;
         packets_checked = 0;
         bytes_taken = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == WIDTH_ADDR)
               width_reg = pwdata[SIZE_WIDTH-1:0];
            else if (paddr == HEIGHT_ADDR)
               height_reg = pwdata[SIZE_WIDTH-1:0];
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            if (req_aux_data)
               advance_framer(req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (cursor_q.size() == 0) begin
               report_mismatch("cursor beat with no packet outstanding, cursor_x",
                               int'(rsp_cursor_x), -1);
            end else begin
               want = cursor_q.pop_front();
               packets_checked++;
               if (rsp_cursor_x !== want.x)
                  report_mismatch("cursor_x", int'(rsp_cursor_x), int'(want.x));
               if (rsp_cursor_y !== want.y)
                  report_mismatch("cursor_y", int'(rsp_cursor_y), int'(want.y));
               if (rsp_buttons !== want.buttons)
                  report_mismatch("buttons", int'(rsp_buttons), int'(want.buttons));
            end
         end
      end
      pending = cursor_q.size();
   end

endmodule

[sim/pointer_packet_cursor_tracker_core_test.sv]
// ----------------------------------------------------------------------------
// pointer_packet_cursor_tracker_core_test
// Byte stream stimulus and verdict for the pointer packet cursor tracker.
// ----------------------------------------------------------------------------
// A directed opening covers ignored bytes, headers that lose sync, sign and
// button extremes and clamping at the low edges. Then the screen size is moved
// through a series of settings, from one pixel and zero up to sizes past the
// coordinate range, each followed by random packets drifting toward an edge
// with some stray bytes mixed in. Both channels idle at random, except in one
// quiet phase; the cursor side is also held off for a long stretch once.
// ----------------------------------------------------------------------------
module pointer_packet_cursor_tracker_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pptrk_pkg::*;

   localparam int CW = COORD_WIDTH_DEFAULT;
   localparam int NUM_SETTINGS = 8;
   localparam int PACKETS_PER_SETTING = 21;
   localparam int HOLD_CYCLES = 80;
   localparam logic [CSR_ADDR_WIDTH-1:0] WIDTH_ADDR  = {REG_SCREEN_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] HEIGHT_ADDR = {REG_SCREEN_HEIGHT, 2'b00};
   localparam logic [SIZE_WIDTH-1:0] WIDTHS [NUM_SETTINGS] =
      '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd640, 13'd2, 13'd1024, 13'd300};
   localparam logic [SIZE_WIDTH-1:0] HEIGHTS [NUM_SETTINGS] =
      '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd480, 13'd4095, 13'd768, 13'd200};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_data_byte = '0;
   logic                      req_aux_data = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CW-1:0]             rsp_cursor_x;
   logic [CW-1:0]             rsp_cursor_y;
   logic [2:0]                rsp_buttons;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int   failures;
   int   pending;
   int   packets_checked;
   int   bytes_taken;
   logic calm = 1'b0;
   logic want_hold = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pointer_packet_cursor_tracker_core #(.COORD_WIDTH(CW)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_byte(req_data_byte),
      .req_aux_data (req_aux_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_cursor_x (rsp_cursor_x),
      .rsp_cursor_y (rsp_cursor_y),
      .rsp_buttons  (rsp_buttons),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   pointer_packet_cursor_tracker_core_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_aux_data   (req_aux_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_x   (rsp_cursor_x),
      .rsp_cursor_y   (rsp_cursor_y),
      .rsp_buttons    (rsp_buttons),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .failures       (failures),
      .pending        (pending),
      .packets_checked(packets_checked),
      .bytes_taken    (bytes_taken)
   );

   // Cursor side: random stalls, none in the quiet phase, and one long hold
   // on request so the byte side backs up.
   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (want_hold) begin
            want_hold = 1'b0;
            rsp_stall <= 1'b1;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 22);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the beat
   // is taken, with valid still high so back-to-back beats need no toggle.
   task automatic push_byte(logic [7:0] b, logic aux);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_aux_data <= aux;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_aux(logic [7:0] b);
      if ($urandom_range(99) < 4)
         push_byte(8'($urandom), 1'b0);
      push_byte(b, 1'b1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      // The last bytes of a packet may still sit in the pipeline.
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_WIDTH-1:0] addr, logic [SIZE_WIDTH-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= CSR_DATA_WIDTH'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // A device move pushing the cursor in direction dir most of the time.
   function automatic logic [8:0] pick_move(int dir);
      if ($urandom_range(99) < 65)
         return (dir > 0) ? 9'($urandom_range(100, 255)) : 9'(512 - $urandom_range(100, 256));
      return 9'($urandom_range(0, 511));
   endfunction

   task automatic send_packet(int drift_x, int drift_y);
      logic [8:0] mx;
      logic [8:0] my;
      logic [7:0] hdr;
      if ($urandom_range(99) < 6) begin
         hdr = 8'($urandom);
         hdr[HDR_SYNC_BIT] = 1'b0;
         push_byte(hdr, 1'b1);
      end
      mx = pick_move(drift_x);
      my = pick_move(-drift_y);
      hdr = 8'($urandom);
      hdr[HDR_SYNC_BIT] = 1'b1;
      hdr[HDR_XSIGN_BIT] = mx[8];
      hdr[HDR_YSIGN_BIT] = my[8];
      send_aux(hdr);
      send_aux(mx[7:0]);
      send_aux(my[7:0]);
   endtask

   initial begin
      logic [SIZE_WIDTH-1:0] w;
      logic [SIZE_WIDTH-1:0] h;
      int drift_x;
      int drift_y;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Bytes off the mouse channel and headers without sync are dropped.
      push_byte(8'hFF, 1'b0);
      push_byte(8'hF7, 1'b1);
      push_byte(8'h00, 1'b1);
      // All buttons, largest positive X.
      push_byte(8'h0F, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      // Both moves at their most negative; X clamps at zero.
      push_byte(8'h38, 1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'h00, 1'b1);
      // A stray byte inside a packet leaves the framing alone.
      push_byte(8'h09, 1'b1);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h7F, 1'b1);
      push_byte(8'h01, 1'b1);
      // Overflow bits set; Y clamps at zero.
      push_byte(8'hC8, 1'b1);
      push_byte(8'h80, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h1A, 1'b1);
      push_byte(8'h01, 1'b1);
      push_byte(8'h80, 1'b1);
      push_byte(8'h2C, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h01, 1'b1);

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         wait_idle();
         w = WIDTHS[s];
         h = HEIGHTS[s];
         if (s == NUM_SETTINGS - 1) begin
            w = SIZE_WIDTH'($urandom_range(1, 4096));
            h = SIZE_WIDTH'($urandom_range(1, 4096));
         end
         write_reg(WIDTH_ADDR, w);
         write_reg(HEIGHT_ADDR, h);
         calm = (s == 3);
         drift_x = $urandom_range(1) ? 1 : -1;
         drift_y = $urandom_range(1) ? 1 : -1;
         // Walk toward the far corner on the big screens, back on the next.
         if (s == 2 || s == 3) begin
            drift_x = 1;
            drift_y = 1;
         end else if (s == 4) begin
            drift_x = -1;
            drift_y = -1;
         end
         for (int k = 0; k < PACKETS_PER_SETTING; k++) begin
            if (s == 4 && k == 4)
               want_hold = 1'b1;
            if (s == 5 && k == 12)
               wait_idle();
            send_packet(drift_x, drift_y);
         end
      end
      calm = 1'b0;
      wait_idle();
      repeat (10) @(negedge clock);

      $display("Checked %0d cursor beats from %0d accepted bytes over %0d screen settings,",
               packets_checked, bytes_taken, NUM_SETTINGS + 1);
      $display("with stray bytes, lost-sync headers, a long output hold and a full drain.");
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
rtl/core/pptrk_pkg.sv
rtl/core/pptrk_csr.sv
rtl/core/pptrk_decoder.sv
rtl/core/pointer_packet_cursor_tracker_core.sv
sim/pointer_packet_cursor_tracker_core_checker.sv
sim/pointer_packet_cursor_tracker_core_test.sv
